// ===== rtl/assert_macros.svh =====
// Assertion macros used by the RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Concurrent assertion on an explicit clock and active-low reset.
`define ASSERT_CLK(label, clk, rst_n, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// Same, on the house clock and reset names.
`define ASSERT_STD(label, prop, msg) `ASSERT_CLK(label, clk_i, rst_ni, prop, msg)

`endif

// ===== rtl/ogdd_pkg.sv =====
// Types, constants and functions of the danger dilation block.
package ogdd_pkg;

  localparam int unsigned RowWidth   = 64;
  localparam int unsigned MaxRows    = 1024;
  localparam int unsigned HistDepth  = 4;
  localparam int unsigned MaxResults = 3;
  localparam int unsigned FifoDepth  = 4;

  localparam int unsigned IdxW = $clog2(MaxRows);
  localparam int unsigned ColW = $clog2(RowWidth) + 1;
  localparam int unsigned PtrW = $clog2(FifoDepth);
  localparam int unsigned CntW = $clog2(FifoDepth) + 1;

  localparam logic [IdxW-1:0] MaxIdx = IdxW'(MaxRows - 1);

  typedef logic [RowWidth-1:0] row_t;

  typedef struct packed {
    logic shift;
    logic clear;
  } cell_ctrl_t;

  typedef struct packed {
    row_t            danger;
    logic [IdxW-1:0] index;
    logic            done;
  } result_t;

  typedef struct packed {
    logic    [MaxResults-1:0] valid;
    result_t [MaxResults-1:0] item;
  } push_t;

  // Columns below the active width are set.
  function automatic row_t column_mask(input logic [ColW-1:0] cols);
    logic [ColW-1:0] w;
    row_t            m;
    w = (cols > ColW'(RowWidth)) ? ColW'(RowWidth) : cols;
    for (int k = 0; k < RowWidth; k++) begin
      m[k] = (ColW'(k) < w);
    end
    return m;
  endfunction

  // Danger bits of the middle row c of a five-row window.
  function automatic row_t danger_of(input row_t a, input row_t b, input row_t c,
                                     input row_t d, input row_t e, input row_t mask);
    row_t v;
    row_t h;
    v = (a | b | c | d | e) & mask;
    h = v | (v << 1) | (v << 2) | (v >> 1) | (v >> 2);
    return h & ~c & mask;
  endfunction

  // Row index of a result lagging the current row by lag, saturating.
  function automatic logic [IdxW-1:0] index_of(input logic [IdxW-1:0] count,
                                               input logic [1:0]      lag);
    return (count >= MaxIdx) ? MaxIdx : count - IdxW'(lag);
  endfunction

endpackage

// ===== rtl/ogdd_row_cell.sv =====
// One history cell: holds a grid row and hands it to the next cell.
module ogdd_row_cell (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  ogdd_pkg::cell_ctrl_t ctrl_i,
  input  ogdd_pkg::row_t     row_i,
  output ogdd_pkg::row_t     row_o
);
  import ogdd_pkg::*;

  row_t row_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      row_q <= '0;
    end else if (ctrl_i.clear) begin
      row_q <= '0;
    end else if (ctrl_i.shift) begin
      row_q <= row_i;
    end
  end

  assign row_o = row_q;

endmodule

// ===== rtl/ogdd_result_fifo.sv =====
// Result queue: takes up to three items at once, gives one per cycle while the reader is ready.
module ogdd_result_fifo (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  ogdd_pkg::push_t   push_i,
  output logic              push_ready_o,
  output logic              pop_valid_o,
  input  logic              pop_ready_i,
  output ogdd_pkg::result_t head_o
);
  import ogdd_pkg::*;

  result_t         mem_q [FifoDepth];
  logic [PtrW-1:0] wr_ptr_q, wr_ptr_d;
  logic [PtrW-1:0] rd_ptr_q, rd_ptr_d;
  logic [CntW-1:0] cnt_q, cnt_d;
  logic [PtrW-1:0] wr_idx [MaxResults];
  logic [CntW-1:0] n_push;
  logic            pop;

  // Packed write slots: each valid item goes after the ones before it.
  always_comb begin
    n_push = '0;
    for (int j = 0; j < MaxResults; j++) begin
      wr_idx[j] = wr_ptr_q + PtrW'(n_push);
      n_push    = n_push + CntW'(push_i.valid[j]);
    end
  end

  assign pop          = pop_valid_o && pop_ready_i;
  assign pop_valid_o  = (cnt_q != '0);
  assign push_ready_o = (cnt_q <= CntW'(FifoDepth - MaxResults));
  assign head_o       = mem_q[rd_ptr_q];

  assign wr_ptr_d = wr_ptr_q + PtrW'(n_push);
  assign rd_ptr_d = rd_ptr_q + PtrW'(pop);
  assign cnt_d    = cnt_q + n_push - CntW'(pop);

  always_ff @(posedge clk_i) begin
    for (int j = 0; j < MaxResults; j++) begin
      if (push_i.valid[j]) begin
        mem_q[wr_idx[j]] <= push_i.item[j];
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

endmodule

// ===== rtl/occupancy_grid_danger_dilation_unit.sv =====
// Top level of the occupancy grid danger dilation block.
`include "assert_macros.svh"

// Streams an occupancy grid one row per item (bit k = column k occupied) and
// returns, per grid row, the cells that are free but lie within two rows and
// two columns of an occupied cell (5x5 square dilation). Rows outside the
// grid and columns at or above active_columns count as empty; output bits
// above the active width are zero. The danger row for row n-2 is produced
// when row n is accepted; a final_row item flushes rows n-1 and n as well
// (grid_done set on the last one) and clears the history for the next grid.
// row_index saturates at 1023. Rate: one row per cycle whenever the sink
// takes a result each cycle. Results are written, as their row is accepted,
// into a four-entry queue, and the input stalls while more than one result
// waits there, so a final row that makes three results holds the input
// until the sink has taken results. History lives in a chain of four row
// cells that shift by one on every accepted normal row; a final row clears
// them. active_columns is written over its own valid/ready channel, which is
// always ready, and should only change while the block is idle.
module occupancy_grid_danger_dilation_unit (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  // config channel
  input  logic                           cfg_valid_i,
  output logic                           cfg_ready_o,
  input  logic [ogdd_pkg::ColW-1:0]      cfg_active_columns_i,
  // row input channel
  input  logic                           in_valid_i,
  output logic                           in_ready_o,
  input  logic [ogdd_pkg::RowWidth-1:0]  occupied_row_i,
  input  logic                           final_row_i,
  // danger output channel
  output logic                           out_valid_o,
  input  logic                           out_ready_i,
  output logic [ogdd_pkg::RowWidth-1:0]  danger_row_o,
  output logic [ogdd_pkg::IdxW-1:0]      row_index_o,
  output logic                           grid_done_o
);
  import ogdd_pkg::*;

  logic [ColW-1:0] active_cols_q;
  logic [IdxW-1:0] rows_q, rows_d;
  logic            accept;
  row_t            mask;
  row_t            row_masked;
  row_t            hist    [HistDepth];  // hist[0] is the newest row
  row_t            cell_in [HistDepth];
  cell_ctrl_t      cell_ctrl;
  push_t           push;
  result_t         head;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      active_cols_q <= ColW'(RowWidth);
    end else if (cfg_valid_i && cfg_ready_o) begin
      active_cols_q <= cfg_active_columns_i;
    end
  end

  assign accept     = in_valid_i && in_ready_o;
  assign mask       = column_mask(active_cols_q);
  assign row_masked = occupied_row_i & mask;

  // History chain: normal rows shift in, the final row wipes it.
  assign cell_ctrl.shift = accept && !final_row_i;
  assign cell_ctrl.clear = accept && final_row_i;

  for (genvar k = 0; k < HistDepth; k++) begin : g_cell
    if (k == 0) begin : g_head
      assign cell_in[k] = row_masked;
    end else begin : g_link
      assign cell_in[k] = hist[k-1];
    end
    ogdd_row_cell u_cell (
      .clk_i  (clk_i),
      .rst_ni (rst_ni),
      .ctrl_i (cell_ctrl),
      .row_i  (cell_in[k]),
      .row_o  (hist[k])
    );
  end

  // Rows seen in the current grid, saturating.
  always_comb begin
    rows_d = rows_q;
    if (accept) begin
      if (final_row_i) begin
        rows_d = '0;
      end else if (rows_q < MaxIdx) begin
        rows_d = rows_q + 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rows_q <= '0;
    end else begin
      rows_q <= rows_d;
    end
  end

  // Slot 0: row n-2 with full window. Slots 1 and 2 only on the final row:
  // flushes of rows n-1 and n with empty rows below the grid.
  always_comb begin
    push.valid[0]       = accept && (rows_q >= IdxW'(2));
    push.item[0].danger = danger_of(hist[3], hist[2], hist[1], hist[0], row_masked, mask);
    push.item[0].index  = index_of(rows_q, 2'd2);
    push.item[0].done   = 1'b0;

    push.valid[1]       = accept && final_row_i && (rows_q >= IdxW'(1));
    push.item[1].danger = danger_of(hist[2], hist[1], hist[0], row_masked, '0, mask);
    push.item[1].index  = index_of(rows_q, 2'd1);
    push.item[1].done   = 1'b0;

    push.valid[2]       = accept && final_row_i;
    push.item[2].danger = danger_of(hist[1], hist[0], row_masked, '0, '0, mask);
    push.item[2].index  = index_of(rows_q, 2'd0);
    push.item[2].done   = 1'b1;
  end

  ogdd_result_fifo u_fifo (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push_i       (push),
    .push_ready_o (in_ready_o),
    .pop_valid_o  (out_valid_o),
    .pop_ready_i  (out_ready_i),
    .head_o       (head)
  );

  assign danger_row_o = head.danger;
  assign row_index_o  = head.index;
  assign grid_done_o  = head.done;

  // A final row leaves the newest and oldest history rows empty and a zero row count behind.
  `ASSERT_STD(a_final_clears, (accept && final_row_i) |=> ((rows_q == '0) && (hist[0] == '0) && (hist[3] == '0)), "history not cleared after final row")
  // Row count never passes its saturation value.
  `ASSERT_STD(a_rows_sat, rows_q <= MaxIdx, "row count past saturation")
  // Any item that makes a result has one waiting on the next cycle.
  `ASSERT_STD(a_result_shows, (accept && (final_row_i || (rows_q >= IdxW'(2)))) |=> out_valid_o, "result missing after accepted row")

endmodule
